[sv/pssh_pkg.sv]
package pssh_pkg;

    localparam int DIODES_DEF = 64;

    localparam int SLICE_W  = 64;
    localparam int WIDTH_W  = 16;
    localparam int HEIGHT_W = 7;
    localparam int AREA_W   = 22;
    localparam int COUNT_W  = 32;
    localparam int SHADOW_W = 40;
    localparam int RATIO_W  = 16;
    localparam int BIN_W    = 7;

    localparam logic [17:0] PI_Q16 = 18'd205887;

    typedef enum logic [1:0] {
        CMD_SLICE = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [SLICE_W-1:0]  slice_bits;
        logic                dof_reject;
        logic                hist_select;
        logic [BIN_W-1:0]    bin_index;
    } t_in;

    typedef struct packed {
        logic [WIDTH_W-1:0]  cur_width;
        logic [HEIGHT_W-1:0] cur_height;
        logic [AREA_W-1:0]   cur_area;
        logic                took_1d;
        logic                took_2d;
        logic                too_big;
        logic [COUNT_W-1:0]  bin_count;
        logic [SHADOW_W-1:0] shadow_total;
        logic [COUNT_W-1:0]  reject_1d_total;
        logic [COUNT_W-1:0]  reject_2d_total;
        logic [COUNT_W-1:0]  oversize_total;
    } t_out;

endpackage

[sv/pssh_ram.sv]
module pssh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/particle_slice_sizer_histogram.sv]
// Particle sizer and size histograms for an optical-array probe.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): one command per
// item, a raw inverted slice, an end of particle, a bin read or a clear. Each
// item yields one result (o_out_valid / i_out_stall, payload o_out_item).
//
// One item at a time: a slice or a clear has its own state, a read passes
// read-request and read-data, an end of particle the max-square, low and
// high partial-product, decision and update states, and the next item is
// taken back in idle. An end forms the area-ratio product from two 34x16
// partial products and read-modify-writes the two histogram memories.
//
// While the receiver stalls the output register holds; one more item is
// accepted and its result waits in a holding register, input stalled, until
// the output register is free.
//
// Reset clears the particle, all totals and the histogram valid bits; bins
// read as zero until written; clear drops the valid bits and shadow total.
// Write the ratio register only while no item is in flight.
module particle_slice_sizer_histogram
    import pssh_pkg::*;
#(
    parameter int DIODES = DIODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic [RATIO_W-1:0] i_cfg_wr_data
);

    localparam int H1_DEPTH = DIODES;
    localparam int H2_DEPTH = 2 * DIODES;
    localparam int A1W      = $clog2(H1_DEPTH);
    localparam int A2W      = $clog2(H2_DEPTH);
    localparam int K_W      = RATIO_W + 18;
    localparam int PP_W     = K_W + 16;
    localparam int PROD_W   = PP_W + 16;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SLICE = 11'b000_0000_0010,
        S_MSQ   = 11'b000_0000_0100,
        S_PLO   = 11'b000_0000_1000,
        S_PHI   = 11'b000_0001_0000,
        S_DEC   = 11'b000_0010_0000,
        S_UPD   = 11'b000_0100_0000,
        S_RDREQ = 11'b000_1000_0000,
        S_RDDAT = 11'b001_0000_0000,
        S_CLR   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    t_state               r_state;
    t_in                  r_in;
    t_out                 r_res, n_res, r_out;
    logic                 r_out_valid;
    logic [RATIO_W-1:0]   r_area_ratio;
    logic [K_W-1:0]       r_k;

    logic [WIDTH_W-1:0]   r_width, n_width;
    logic [HEIGHT_W-1:0]  r_height, n_height;
    logic [AREA_W-1:0]    r_area, n_area;
    logic                 r_edge, n_edge;
    logic [SHADOW_W-1:0]  r_shadow, n_shadow;
    logic [COUNT_W-1:0]   r_rej1, n_rej1, r_rej2, n_rej2, r_over, n_over;
    logic [H1_DEPTH-1:0]  r_v1, n_v1;
    logic [H2_DEPTH-1:0]  r_v2, n_v2;

    logic [2*WIDTH_W-1:0] r_m2;
    logic [A1W-1:0]       r_a1;
    logic [A2W-1:0]       r_a2;
    logic                 r_in1, r_in2;
    logic [PP_W-1:0]      r_plo, r_phi;
    logic                 r_ok1, r_ok2;

    logic [DIODES-1:0]    w_s;
    logic [HEIGHT_W-1:0]  w_cnt, w_hi, w_lo, w_span;
    logic [AREA_W:0]      w_asum;
    logic [SHADOW_W:0]    w_ssum;
    logic [WIDTH_W-1:0]   w_m;
    logic                 w_stuck, w_rfail, w_wide;
    logic [PROD_W-1:0]    w_prod, w_lhs;
    logic                 w_finish, w_out_free, w_keep;
    logic [COUNT_W-1:0]   w_q1, w_q2, w_bin;

    logic                 w_wr1, w_wr2, w_rd;
    logic [COUNT_W-1:0]   w_wd1, w_wd2;
    logic [A1W-1:0]       w_ra1;
    logic [A2W-1:0]       w_ra2;

    pssh_ram #(.WIDTH(COUNT_W), .DEPTH(H1_DEPTH)) u_hist1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr1),
        .i_wr_addr (r_a1),
        .i_wr_data (w_wd1),
        .i_rd_en   (w_rd),
        .i_rd_addr (w_ra1),
        .o_rd_data (w_q1)
    );

    pssh_ram #(.WIDTH(COUNT_W), .DEPTH(H2_DEPTH)) u_hist2 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr2),
        .i_wr_addr (r_a2),
        .i_wr_data (w_wd2),
        .i_rd_en   (w_rd),
        .i_rd_addr (w_ra2),
        .o_rd_data (w_q2)
    );

    assign w_rd  = (r_state == S_MSQ) || (r_state == S_RDREQ);
    assign w_ra1 = (r_state == S_MSQ) ? r_height[A1W-1:0] : r_in.bin_index[A1W-1:0];
    assign w_ra2 = (r_state == S_MSQ) ? w_m[A2W-1:0] : r_in.bin_index[A2W-1:0];

    assign w_s   = ~r_in.slice_bits[DIODES-1:0];
    assign w_cnt = HEIGHT_W'($countones(w_s));

    always_comb begin
        w_hi = '0;
        w_lo = '0;
        for (int i = 0; i < DIODES; i++) begin
            if (w_s[i]) w_hi = HEIGHT_W'(i);
        end
        for (int i = DIODES - 1; i >= 0; i--) begin
            if (w_s[i]) w_lo = HEIGHT_W'(i);
        end
    end

    assign w_span  = w_hi - w_lo + HEIGHT_W'(1);
    assign w_asum  = {1'b0, r_area} + (AREA_W + 1)'(w_cnt);
    assign w_ssum  = {1'b0, r_shadow} + (SHADOW_W + 1)'(r_area);
    assign w_m     = (r_width > WIDTH_W'(r_height)) ? r_width : WIDTH_W'(r_height);
    assign w_stuck = (r_height == HEIGHT_W'(1)) && (r_width > WIDTH_W'(3));
    assign w_wide  = r_width > WIDTH_W'({r_height, 1'b0});
    assign w_prod  = {r_phi, 16'b0} + PROD_W'(r_plo);
    assign w_lhs   = PROD_W'({r_area, 34'b0});
    assign w_rfail = w_prod >= w_lhs;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_area   = r_area;
        n_edge   = r_edge;
        n_shadow = r_shadow;
        n_rej1   = r_rej1;
        n_rej2   = r_rej2;
        n_over   = r_over;
        n_v1     = r_v1;
        n_v2     = r_v2;
        w_wr1    = 1'b0;
        w_wr2    = 1'b0;
        w_wd1    = sat_inc(r_v1[r_a1] ? w_q1 : '0);
        w_wd2    = sat_inc(r_v2[r_a2] ? w_q2 : '0);
        w_bin    = '0;
        w_finish = 1'b0;
        n_res    = '0;
        unique case (r_state)
            S_SLICE: begin
                n_width = (r_width == '1) ? r_width : r_width + WIDTH_W'(1);
                n_edge  = r_edge | w_s[DIODES-1] | w_s[0];
                n_area  = w_asum[AREA_W] ? '1 : w_asum[AREA_W-1:0];
                if ((w_s != '0) && (w_span > r_height)) begin
                    n_height = w_span;
                end
                w_finish = 1'b1;
            end
            S_UPD: begin
                if (r_ok1) begin
                    n_res.took_1d = 1'b1;
                    if (r_in1) begin
                        w_wr1      = 1'b1;
                        n_v1[r_a1] = 1'b1;
                    end
                    n_shadow = w_ssum[SHADOW_W] ? '1 : w_ssum[SHADOW_W-1:0];
                end else begin
                    n_rej1 = sat_inc(r_rej1);
                end
                if (r_ok2) begin
                    if (r_in2) begin
                        n_res.took_2d = 1'b1;
                        w_wr2         = 1'b1;
                        n_v2[r_a2]    = 1'b1;
                    end else begin
                        n_res.too_big = 1'b1;
                        n_over        = sat_inc(r_over);
                    end
                end else begin
                    n_rej2 = sat_inc(r_rej2);
                end
                n_width  = '0;
                n_height = '0;
                n_area   = '0;
                n_edge   = 1'b0;
                w_finish = 1'b1;
            end
            S_RDDAT: begin
                if (!r_in.hist_select) begin
                    if ((r_in.bin_index < BIN_W'(H1_DEPTH)) && r_v1[r_in.bin_index[A1W-1:0]]) begin
                        w_bin = w_q1;
                    end
                end else begin
                    if (({1'b0, r_in.bin_index} < (BIN_W + 1)'(H2_DEPTH))
                        && r_v2[r_in.bin_index[A2W-1:0]]) begin
                        w_bin = w_q2;
                    end
                end
                w_finish = 1'b1;
            end
            S_CLR: begin
                n_v1     = '0;
                n_v2     = '0;
                n_shadow = '0;
                w_finish = 1'b1;
            end
            default: ;
        endcase
        w_keep                = (r_state == S_UPD);
        n_res.cur_width       = w_keep ? r_width  : n_width;
        n_res.cur_height      = w_keep ? r_height : n_height;
        n_res.cur_area        = w_keep ? r_area   : n_area;
        n_res.bin_count       = w_bin;
        n_res.shadow_total    = n_shadow;
        n_res.reject_1d_total = n_rej1;
        n_res.reject_2d_total = n_rej2;
        n_res.oversize_total  = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_area_ratio <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_area       <= '0;
            r_edge       <= 1'b0;
            r_shadow     <= '0;
            r_rej1       <= '0;
            r_rej2       <= '0;
            r_over       <= '0;
            r_v1         <= '0;
            r_v2         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_area_ratio <= i_cfg_wr_data;
            end
            r_width  <= n_width;
            r_height <= n_height;
            r_area   <= n_area;
            r_edge   <= n_edge;
            r_shadow <= n_shadow;
            r_rej1   <= n_rej1;
            r_rej2   <= n_rej2;
            r_over   <= n_over;
            r_v1     <= n_v1;
            r_v2     <= n_v2;

            if (((w_finish || r_state == S_DONE)) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_in_item.command)
                            CMD_SLICE: r_state <= S_SLICE;
                            CMD_END:   r_state <= S_MSQ;
                            CMD_READ:  r_state <= S_RDREQ;
                            CMD_CLEAR: r_state <= S_CLR;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MSQ:   r_state <= S_PLO;
                S_PLO:   r_state <= S_PHI;
                S_PHI:   r_state <= S_DEC;
                S_DEC:   r_state <= S_UPD;
                S_RDREQ: r_state <= S_RDDAT;
                S_DONE: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: begin
                    if (w_finish) begin
                        r_state <= w_out_free ? S_IDLE : S_DONE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= K_W'(r_area_ratio) * K_W'(PI_Q16);
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (r_state == S_MSQ) begin
            r_m2  <= (2 * WIDTH_W)'(w_m) * (2 * WIDTH_W)'(w_m);
            r_a1  <= r_height[A1W-1:0];
            r_a2  <= w_m[A2W-1:0];
            r_in1 <= r_height < HEIGHT_W'(H1_DEPTH);
            r_in2 <= w_m < WIDTH_W'(H2_DEPTH);
        end
        if (r_state == S_PLO) begin
            r_plo <= PP_W'(r_k) * PP_W'(r_m2[15:0]);
        end
        if (r_state == S_PHI) begin
            r_phi <= PP_W'(r_k) * PP_W'(r_m2[31:16]);
        end
        if (r_state == S_DEC) begin
            r_ok1 <= !r_in.dof_reject && !r_edge && (r_height != '0) && !w_stuck && !w_rfail;
            r_ok2 <= !r_in.dof_reject && !w_stuck && !w_rfail && !(r_edge && w_wide);
        end
        if (w_finish) begin
            if (w_out_free) begin
                r_out <= n_res;
            end else begin
                r_res <= n_res;
            end
        end else if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[sv/pssh_checker.sv]
module pssh_checker
    import pssh_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input t_in                i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out               o_out_item,
    input logic               i_cfg_wr_en,
    input logic [RATIO_W-1:0] i_cfg_wr_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.took_2d && o_out_item.too_big))
        else $error("2D bin and oversize both flagged");

    a_took1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.took_1d |-> o_out_item.cur_height != '0)
        else $error("1D accept with zero height");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind particle_slice_sizer_histogram pssh_checker u_pssh_checker (.*);
